/* hdl/rq_pkg.sv */
// ============================================================================
// rq_pkg
// Shared types and constants of the ring queue with search.
// ============================================================================
package rq_pkg;

   localparam int RING_DEPTH = 64;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int OCC_W      = $clog2(RING_DEPTH + 1);
   localparam int CAP_W      = 7;
   localparam int WORD_W     = 32;
   localparam int KIND_W     = 3;
   localparam int STAT_W     = 2;
   localparam int RSP_BITS   = WORD_W + SLOT_W + OCC_W + 1;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENQ    = 3'd0,
      KIND_DEQ    = 3'd1,
      KIND_PEEK   = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_SEARCH = 3'd4
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_REFUSED  = 2'd1,
      STAT_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCAN
   } state_type;

   typedef struct packed {
      status_type          status;
      logic [WORD_W-1:0]   data;
      logic [SLOT_W-1:0]   slot;
      logic [OCC_W-1:0]    occupancy;
      logic                is_full;
   } result_type;

endpackage

/* hdl/ring_queue_with_search.sv */
// ============================================================================
// ring_queue_with_search
// Circular queue of 32-bit words in a synchronous ring store, with search.
// ============================================================================
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ------------------------------------
//  req_     in   req_tvalid/req_tready  tuser: kind, tdata: value
//  rsp_     out  rsp_tvalid/rsp_tready  tuser: status, tdata: data, slot,
//                                       occupancy, is_full
//  csr_     in   csr_valid/csr_ready    capacity_in_use (empties the queue)
//
//  Enqueue, clear and unknown kinds finish in the execute state, dequeue
//  and peek add one ring store read, which is skipped when refused on an
//  empty queue. Search compares the entries up to the first match, one per
//  cycle through the single read port.
//  Reset empties the queue and sets the capacity to 64; the ring store
//  itself is not cleared. A new word is taken while the previous result
//  still waits in the output register; a stalled output holds the sequencer.
//
module ring_queue_with_search
   import rq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // value
   input  logic [KIND_W-1:0] req_tuser,   // kind

   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // data, slot, occupancy, is_full, zero pad
   output logic [STAT_W-1:0] rsp_tuser,   // status

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data     // capacity_in_use
);

   logic [OCC_W-1:0] cap_ff, cap_in;
   logic             csr_write;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff;
   logic             out_free;
   logic             res_valid;
   result_type       res;

   // capacity register: always writable, stores the effective value
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      if (csr_data == '0) begin
         cap_in = OCC_W'(1);
      end else if (32'(csr_data) > 32'(RING_DEPTH)) begin
         cap_in = OCC_W'(RING_DEPTH);
      end else begin
         cap_in = OCC_W'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= OCC_W'(RING_DEPTH);
      end else if (csr_write) begin
         cap_ff <= cap_in;
      end
   end

   rq_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_kind (req_tuser),
      .req_value(req_tdata),
      .cap      (cap_ff),
      .flush    (csr_write),
      .out_free (out_free),
      .res_valid(res_valid),
      .res      (res)
   );

   // output register: load a finished result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = RSP_W'({rsp_ff.is_full, rsp_ff.occupancy, rsp_ff.slot, rsp_ff.data});

endmodule

/* hdl/rq_ram.sv */
// ============================================================================
// rq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module rq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rq_core.sv */
// ============================================================================
// rq_core
// Request sequencer: pointers, count, ring store access and search walk.
// ============================================================================
module rq_core
   import rq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [WORD_W-1:0] req_value,
   input  logic [OCC_W-1:0]  cap,
   input  logic              flush,
   input  logic              out_free,
   output logic              res_valid,
   output result_type        res
);

   state_type           state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff;
   logic [WORD_W-1:0]   value_ff;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic [OCC_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]   scan_ff, scan_in;
   logic [OCC_W-1:0]    seen_ff, seen_in;

   logic                mem_wr_en;
   logic [SLOT_W-1:0]   mem_rd_addr;
   logic [WORD_W-1:0]   mem_rd_data;

   logic                full;
   logic                empty;
   logic                hit;
   logic                last;

   // advance a slot pointer around the active ring
   function automatic logic [SLOT_W-1:0] wrap_inc(logic [SLOT_W-1:0] p,
                                                  logic [OCC_W-1:0] c);
      logic [OCC_W-1:0] n;
      n = OCC_W'(p) + 1'b1;
      return (n >= c) ? '0 : n[SLOT_W-1:0];
   endfunction

   assign full  = (count_ff >= cap);
   assign empty = (count_ff == '0);
   assign hit   = (mem_rd_data == value_ff);
   assign last  = ((seen_ff + 1'b1) == count_ff);

   assign req_ready = (state_ff == ST_IDLE);

   rq_ram #(
      .WIDTH(WORD_W),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(tail_ff),
      .wr_data(value_ff),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (kind_ff)
               KIND_DEQ, KIND_PEEK: begin
                  if (!empty) state_in = ST_READ;
                  else if (out_free) state_in = ST_IDLE;
               end
               KIND_SEARCH: begin
                  if (!empty) state_in = ST_SCAN;
                  else if (out_free) state_in = ST_IDLE;
               end
               default: begin
                  if (out_free) state_in = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if ((hit || last) && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      seen_in       = seen_ff;
      mem_wr_en     = 1'b0;
      mem_rd_addr   = head_ff;
      res_valid     = 1'b0;
      res.status    = STAT_OK;
      res.data      = '0;
      res.slot      = '0;
      case (state_ff)
         ST_EXEC: begin
            case (kind_ff)
               KIND_ENQ: begin
                  if (out_free) begin
                     res_valid = 1'b1;
                     if (full) begin
                        res.status = STAT_REFUSED;
                     end else begin
                        mem_wr_en = 1'b1;
                        tail_in   = wrap_inc(tail_ff, cap);
                        count_in  = count_ff + 1'b1;
                     end
                  end
               end
               KIND_DEQ, KIND_PEEK: begin
                  if (empty && out_free) begin
                     res_valid  = 1'b1;
                     res.status = STAT_REFUSED;
                  end
               end
               KIND_SEARCH: begin
                  scan_in = head_ff;
                  seen_in = '0;
                  if (empty && out_free) begin
                     res_valid  = 1'b1;
                     res.status = STAT_NOTFOUND;
                  end
               end
               KIND_CLEAR: begin
                  if (out_free) begin
                     res_valid = 1'b1;
                     head_in   = '0;
                     tail_in   = '0;
                     count_in  = '0;
                  end
               end
               default: begin
                  res_valid = out_free;
               end
            endcase
         end
         ST_READ: begin
            if (out_free) begin
               res_valid = 1'b1;
               res.data  = mem_rd_data;
               if (kind_ff == KIND_DEQ) begin
                  head_in  = wrap_inc(head_ff, cap);
                  count_in = count_ff - 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  res.slot  = scan_ff;
               end
            end else if (last) begin
               if (out_free) begin
                  res_valid  = 1'b1;
                  res.status = STAT_NOTFOUND;
               end
            end else begin
               scan_in = wrap_inc(scan_ff, cap);
               seen_in = seen_ff + 1'b1;
            end
            mem_rd_addr = scan_in;
         end
         default: begin
         end
      endcase
      res.occupancy = count_in;
      res.is_full   = (count_in >= cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (flush) begin
            head_ff  <= '0;
            tail_ff  <= '0;
            count_ff <= '0;
         end else begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
      scan_ff <= scan_in;
      seen_ff <= seen_in;
   end

endmodule

/* bench/tb_ring_queue_with_search.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_ring_queue_with_search
// Self-checking bench for the ring queue with search. A scoreboard class
// tracks its own copy of the ring, pointers, count and capacity. It predicts
// each result from the request words seen going in and checks them field by
// field against the response words seen coming out. A short directed part
// covers the corner cases. Random phases follow, under several capacities
// and idle patterns, with one long response stall.
// ============================================================================
module tb_ring_queue_with_search;
   import rq_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
   localparam int PHASE_COUNT   = 9;
   localparam int PHASE_ITEMS   = 160;
   localparam int HOLD_CYCLES   = 400;   // long response stall, fills the block
   localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES = 100;   // settle time, longer than the worst search
   localparam int REPORT_LINES  = 100;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts every result and checks the words that come back
   // -------------------------------------------------------------------------
   class queue_scoreboard;
      logic [WORD_W-1:0] ring_words [RING_DEPTH];
      logic [SLOT_W-1:0] head_slot;
      logic [SLOT_W-1:0] tail_slot;
      logic [OCC_W-1:0]  entry_count;
      logic [CAP_W-1:0]  capacity_reg;
      result_type        expected_results [$];
      int unsigned       mismatches;
      int unsigned       requests;
      int unsigned       results;
      int unsigned       refusals;
      int unsigned       search_hits;
      int unsigned       cap_writes;

      function new();
         foreach (ring_words[i]) ring_words[i] = '0;
         capacity_reg = CAP_W'(RING_DEPTH);
         head_slot    = '0;
         tail_slot    = '0;
         entry_count  = '0;
         mismatches   = 0;
         requests     = 0;
         results      = 0;
         refusals     = 0;
         search_hits  = 0;
         cap_writes   = 0;
      endfunction

      // zero behaves as one slot, anything above the ring as the whole ring
      function int live_capacity();
         int c;
         c = int'(capacity_reg);
         if (c == 0) c = 1;
         if (c > RING_DEPTH) c = RING_DEPTH;
         return c;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity_reg = value;
         head_slot    = '0;
         tail_slot    = '0;
         entry_count  = '0;
         cap_writes++;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value);
         result_type r;
         int cap;
         int idx;
         int i;
         cap = live_capacity();
         r.status    = STAT_OK;
         r.data      = '0;
         r.slot      = '0;
         requests++;
         if (int'(head_slot) >= cap) head_slot = '0;
         if (int'(tail_slot) >= cap) tail_slot = '0;
         case (kind)
            KIND_ENQ: begin
               if (int'(entry_count) >= cap) begin
                  r.status = STAT_REFUSED;
               end else begin
                  ring_words[tail_slot] = value;
                  entry_count++;
                  tail_slot = (int'(tail_slot) + 1 >= cap) ? '0 : tail_slot + 1'b1;
               end
            end
            KIND_DEQ: begin
               if (entry_count == '0) begin
                  r.status = STAT_REFUSED;
               end else begin
                  r.data = ring_words[head_slot];
                  entry_count--;
                  head_slot = (int'(head_slot) + 1 >= cap) ? '0 : head_slot + 1'b1;
               end
            end
            KIND_PEEK: begin
               if (entry_count == '0) r.status = STAT_REFUSED;
               else r.data = ring_words[head_slot];
            end
            KIND_CLEAR: begin
               head_slot   = '0;
               tail_slot   = '0;
               entry_count = '0;
            end
            KIND_SEARCH: begin
               // walk oldest to newest, stop at the first match
               r.status = STAT_NOTFOUND;
               for (i = 0; i < int'(entry_count); i++) begin
                  idx = (int'(head_slot) + i) % cap;
                  if (ring_words[idx] == value) begin
                     r.status = STAT_OK;
                     r.slot   = SLOT_W'(idx);
                     search_hits++;
                     break;
                  end
               end
            end
            default: begin
               // spare kinds leave everything as it stands
            end
         endcase
         if (r.status == STAT_REFUSED) refusals++;
         r.occupancy = entry_count;
         r.is_full   = (int'(entry_count) >= cap);
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= REPORT_LINES) $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      task check_result(logic [STAT_W-1:0] status, logic [RSP_W-1:0] word);
         result_type want;
         logic [WORD_W-1:0] got_data;
         logic [SLOT_W-1:0] got_slot;
         logic [OCC_W-1:0]  got_occ;
         logic              got_full;
         got_data = word[WORD_W-1:0];
         got_slot = word[WORD_W +: SLOT_W];
         got_occ  = word[WORD_W + SLOT_W +: OCC_W];
         got_full = word[WORD_W + SLOT_W + OCC_W];
         results++;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d with no request waiting (status %0d, word %h)",
                                      results, status, word));
         end else begin
            want = expected_results.pop_front();
            if (status != want.status)
               report_mismatch($sformatf("result %0d status %0d, want %0d",
                                         results, status, want.status));
            if (got_data != want.data)
               report_mismatch($sformatf("result %0d data %h, want %h",
                                         results, got_data, want.data));
            if (got_slot != want.slot)
               report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                         results, got_slot, want.slot));
            if (got_occ != want.occupancy)
               report_mismatch($sformatf("result %0d occupancy %0d, want %0d",
                                         results, got_occ, want.occupancy));
            if (got_full != want.is_full)
               report_mismatch($sformatf("result %0d is_full %0b, want %0b",
                                         results, got_full, want.is_full));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block's ports
   // -------------------------------------------------------------------------
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata  = '0;   // value
   logic [KIND_W-1:0] req_tuser  = '0;   // kind

   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;         // data, slot, occupancy, is_full, zero pad
   logic [STAT_W-1:0] rsp_tuser;         // status

   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_data   = '0;   // capacity_in_use

   int unsigned       req_idle_pct = 0;
   int unsigned       rsp_idle_pct = 0;
   bit                rsp_hold_go  = 1'b0;

   queue_scoreboard   sb = new();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ring_queue_with_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample every handshake at the edge and feed the scoreboard
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_capacity(csr_data);
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // -------------------------------------------------------------------------
   // Response side: random back-pressure, plus one long hold on request
   // -------------------------------------------------------------------------
   initial begin : response_sink
      forever begin
         @(posedge clock);
         if (rsp_hold_go) begin
            // hold off long enough that the block backs up into its input
            rsp_hold_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run if no handshake of any kind happens for too long
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offer one request word; return at the edge where it is taken.
   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop the request side and wait until every expected result is in.
   // The leading edge lets the monitor record the last accepted word first.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_results.size() != 0) @(posedge clock);
   endtask

   // Write the capacity register, only once the block has gone idle.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly full-range words, some small ones to force duplicate keys,
   // and the signed extremes now and then.
   function automatic logic [WORD_W-1:0] any_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) return $urandom();
      if (pick < 85) return WORD_W'($urandom_range(7));
      case ($urandom_range(3))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Random traffic: weighted single requests, with fill and drain bursts
   // so that the full and empty edges are hit often under every capacity.
   task automatic run_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned pick;
      int unsigned burst;
      int unsigned k;
      logic [WORD_W-1:0] key;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            // fill to the brim and one past it
            burst = sb.live_capacity() + 1;
            for (k = 0; k < burst; k++) send_req(KIND_ENQ, any_word());
            sent += burst;
         end else if (pick < 7) begin
            // empty it and two past it
            burst = sb.entry_count + 2;
            for (k = 0; k < burst; k++) send_req(KIND_DEQ, any_word());
            sent += burst;
         end else begin
            if (pick < 42) begin
               send_req(KIND_ENQ, any_word());
            end else if (pick < 60) begin
               send_req(KIND_DEQ, any_word());
            end else if (pick < 70) begin
               send_req(KIND_PEEK, any_word());
            end else if (pick < 93) begin
               // aim most searches at a word that is actually stored
               key = any_word();
               if (pick < 86 && sb.entry_count != 0)
                  key = sb.ring_words[(int'(sb.head_slot) +
                                       $urandom_range(sb.entry_count - 1)) %
                                      sb.live_capacity()];
               send_req(KIND_SEARCH, key);
            end else if (pick < 96) begin
               send_req(KIND_CLEAR, any_word());
            end else begin
               send_req(KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)),
                        any_word());
            end
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [CAP_W-1:0] cap_plan [PHASE_COUNT];
      int p;
      cap_plan = '{7'd64, 7'd5, 7'd2, 7'd127, 7'd1, 7'd33, 7'd0, 7'd100, 7'd64};
      cap_plan[PHASE_COUNT-1] = CAP_W'($urandom_range(127));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, capacity at its reset value: empty-queue refusals,
      // signed extremes, duplicates, first-match search, spare kinds, clear.
      send_req(KIND_DEQ,    32'h0000_0000);
      send_req(KIND_PEEK,   32'hffff_ffff);
      send_req(KIND_SEARCH, 32'h0000_0005);
      send_req(KIND_ENQ,    32'h8000_0000);
      send_req(KIND_ENQ,    32'h7fff_ffff);
      send_req(KIND_ENQ,    32'h0000_0000);
      send_req(KIND_ENQ,    32'hffff_ffff);
      send_req(KIND_ENQ,    32'h7fff_ffff);
      send_req(KIND_PEEK,   32'h0000_0000);
      send_req(KIND_SEARCH, 32'h7fff_ffff);
      send_req(KIND_SEARCH, 32'hffff_ffff);
      send_req(KIND_SEARCH, 32'h0000_3039);
      send_req(KIND_DEQ,    32'h0000_0000);
      send_req(KIND_SPARE_FIRST,        32'h5555_5555);
      send_req(KIND_SPARE_FIRST + 3'd1, 32'haaaa_aaaa);
      send_req(KIND_SPARE_LAST,         32'h0000_0000);
      send_req(KIND_CLEAR,  32'h0000_0000);
      send_req(KIND_DEQ,    32'h0000_0000);

      // single-slot ring: full after one word
      write_capacity(7'd1);
      send_req(KIND_ENQ,    32'ha5a5_a5a5);
      send_req(KIND_ENQ,    32'h5a5a_5a5a);
      send_req(KIND_SEARCH, 32'ha5a5_a5a5);
      send_req(KIND_DEQ,    32'h0000_0000);

      // zero acts as one slot, the top value as the whole ring
      write_capacity(7'd0);
      send_req(KIND_ENQ,    32'h0000_0001);
      send_req(KIND_ENQ,    32'h0000_0002);
      write_capacity(7'd127);
      send_req(KIND_ENQ,    32'hdead_beef);

      // Random phases: sender sparse / receiver busy, then swapped, then
      // no idling at all; the long response hold opens the last group.
      for (p = 0; p < PHASE_COUNT; p++) begin
         write_capacity(cap_plan[p]);
         if (p < 3) begin
            req_idle_pct = 17;
            rsp_idle_pct = 52;
         end else if (p < 6) begin
            req_idle_pct = 52;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (p == 6) rsp_hold_go = 1'b1;
         run_random(PHASE_ITEMS);
      end

      // drain, then give a worst-case search time to flush anything stray
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_results.size() != 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived",
                                      sb.expected_results.size()));

      $display({"Run covered %0d requests, %0d refused and %0d search hits, ",
                "over %0d capacity writes."},
               sb.requests, sb.refusals, sb.search_hits, sb.cap_writes);
      $display("Checked %0d results, %0d mismatches.", sb.results, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/rq_pkg.sv
hdl/rq_ram.sv
hdl/rq_core.sv
hdl/ring_queue_with_search.sv
bench/tb_ring_queue_with_search.sv
